### sv/lpa_pkg.sv
// ---------------------------------------------------------------------------
// lpa_pkg: shared definitions for the lease pool allocator
// Slot count, index widths, register codes and configuration reset values.
// ---------------------------------------------------------------------------
package lpa_pkg;

  localparam int LEASE_SLOTS = 16;
  localparam int POOLS       = 2;
  localparam int SLOT_W      = (LEASE_SLOTS > 1) ? $clog2(LEASE_SLOTS) : 1;
  localparam int EXP_W       = 33;
  localparam int ADDR_W      = 32;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;
  localparam int RAM_DEPTH   = POOLS * (2 ** SLOT_W);

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_WIRED_BASE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIRELESS_BASE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEASE_SECONDS = 2'd2;

  localparam logic [ADDR_W-1:0] WIRED_BASE_RESET    = 32'd3232235876;
  localparam logic [ADDR_W-1:0] WIRELESS_BASE_RESET = 32'd3232236132;
  localparam logic [ADDR_W-1:0] LEASE_SECONDS_RESET = 32'd1800;

endpackage

### sv/lpa_ram.sv
// ---------------------------------------------------------------------------
// lpa_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module lpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/lease_pool_allocator_unit.sv
// ---------------------------------------------------------------------------
// lease_pool_allocator_unit: two-pool address lease allocator
// Frees expired slots of the requested pool, then grants its lowest free slot.
// ---------------------------------------------------------------------------
// Steps from the accepted request to the result: a sweep that reads the expiry
// of every slot through the RAM read port, a drain step, a grant write step
// and a reply step that forms the address and waits while the result is held.
// A new request is taken only while idle, after the previous result is loaded.
// Reset clears all in-use flags and restores the configuration registers;
// the expiry RAM is not cleared, since an expiry only matters for a slot
// whose in-use flag is set, and that flag is set only by a grant write.
// ---------------------------------------------------------------------------
module lease_pool_allocator_unit (
  input  logic                            clk,
  input  logic                            rst,
  // Configuration write port
  input  logic                            cfg_write,
  input  logic [lpa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lpa_pkg::CFG_DATA_W-1:0]  cfg_data,
  // Request channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            pool_select,
  input  logic [31:0]                     now_seconds,
  // Result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            granted,
  output logic [31:0]                     leased_address,
  output logic [3:0]                      slot_taken
);

  import lpa_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SWEEP,
    S_DRAIN,
    S_GRANT,
    S_REPLY
  } state_t;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(LEASE_SLOTS - 1);

  state_t                   state;

  // Configuration registers.
  logic [ADDR_W-1:0]        wired_base;
  logic [ADDR_W-1:0]        wireless_base;
  logic [ADDR_W-1:0]        lease_seconds;

  // Request held for the duration of the item.
  logic                     pool;
  logic [ADDR_W-1:0]        now_q;

  // One in-use flag per slot of each pool; reset clears them all.
  logic [LEASE_SLOTS-1:0]   in_use [POOLS];

  // Sweep sequencer: cnt issues RAM reads; the compare stage sees each registered read.
  logic [SLOT_W-1:0]        cnt;
  logic                     cmp_valid;
  logic [SLOT_W-1:0]        cmp_idx;
  logic                     found;
  logic [SLOT_W-1:0]        found_idx;

  // Expiry RAM interface.
  logic                     ram_we;
  logic [SLOT_W:0]          ram_waddr;
  logic [EXP_W-1:0]         ram_wdata;
  logic [SLOT_W:0]          ram_raddr;
  logic [EXP_W-1:0]         ram_rdata;

  // Shared adder: expiry in the grant cycle, address in the reply cycle.
  logic [EXP_W-1:0]         add_a;
  logic [EXP_W-1:0]         add_b;
  logic [EXP_W-1:0]         add_sum;

  logic                     slot_busy;
  logic                     slot_expired;
  logic                     slot_free;
  logic                     out_free;

  lpa_ram #(
    .WIDTH (EXP_W),
    .DEPTH (RAM_DEPTH)
  ) u_expiry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // The RAM holds both pools: the pool bit is the top address bit.
  assign ram_raddr = {pool, cnt};
  assign ram_waddr = {pool, found_idx};
  assign ram_wdata = add_sum;
  assign ram_we    = (state == S_GRANT) && found;

  always_comb begin
    unique case (state)
      S_GRANT: begin
        add_a = {1'b0, now_q};
        add_b = {1'b0, lease_seconds};
      end
      S_REPLY: begin
        add_a = {1'b0, pool ? wireless_base : wired_base};
        add_b = EXP_W'(found_idx);
      end
      default: begin
        add_a = '0;
        add_b = '0;
      end
    endcase
  end

  assign add_sum = add_a + add_b;

  // A slot stays busy only if it is in use and its expiry lies after now.
  assign slot_busy    = in_use[pool][cmp_idx];
  assign slot_expired = (ram_rdata <= {1'b0, now_q});
  assign slot_free    = !slot_busy || slot_expired;

  // The result register may be loaded when it is empty or being drained.
  assign out_free = !out_valid || !out_stall;

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      wired_base    <= WIRED_BASE_RESET;
      wireless_base <= WIRELESS_BASE_RESET;
      lease_seconds <= LEASE_SECONDS_RESET;
      for (int p = 0; p < POOLS; p++) begin
        in_use[p] <= '0;
      end
      cnt           <= '0;
      cmp_valid     <= 1'b0;
      found         <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          CFG_WIRED_BASE:    wired_base    <= cfg_data;
          CFG_WIRELESS_BASE: wireless_base <= cfg_data;
          CFG_LEASE_SECONDS: lease_seconds <= cfg_data;
          default: ;
        endcase
      end

      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      // Compare stage: the RAM data for cmp_idx arrives here.
      if (cmp_valid && slot_free) begin
        in_use[pool][cmp_idx] <= 1'b0;
        if (!found) begin
          found     <= 1'b1;
          found_idx <= cmp_idx;
        end
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            pool      <= pool_select;
            now_q     <= now_seconds;
            cnt       <= '0;
            cmp_valid <= 1'b0;
            found     <= 1'b0;
            state     <= S_SWEEP;
          end
        end
        S_SWEEP: begin
          cmp_valid <= 1'b1;
          cmp_idx   <= cnt;
          if (cnt == LAST_SLOT) begin
            state <= S_DRAIN;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_DRAIN: begin
          cmp_valid <= 1'b0;
          state     <= S_GRANT;
        end
        S_GRANT: begin
          if (found) begin
            in_use[pool][found_idx] <= 1'b1;
          end
          state <= S_REPLY;
        end
        S_REPLY: begin
          if (out_free) begin
            out_valid      <= 1'b1;
            granted        <= found;
            leased_address <= found ? add_sum[ADDR_W-1:0] : '0;
            slot_taken     <= found ? 4'(found_idx) : 4'd0;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // A new result appears only out of the reply step.
  a_result_from_reply: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_REPLY)
    else $error("result raised outside the reply step");

  // A refused request reports neither an address nor a slot.
  a_refusal_is_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !granted |-> leased_address == '0 && slot_taken == '0)
    else $error("refused request carries a nonzero address or slot");

  // A grant marks the chosen slot in use.
  a_grant_marks_slot: assert property (@(posedge clk) disable iff (rst)
    state == S_GRANT && found |=> in_use[pool][found_idx])
    else $error("granted slot not marked in use");

  // The sweep never starts the compare stage ahead of the RAM read.
  a_no_compare_first: assert property (@(posedge clk) disable iff (rst)
    state == S_SWEEP && cnt == '0 |-> !cmp_valid)
    else $error("compare stage active before the first expiry read");

endmodule
